/* design/polyline_rect_clipper_defines.svh */
// Assertion helpers used by the checker file.
`ifndef POLYLINE_RECT_CLIPPER_DEFINES_SVH
`define POLYLINE_RECT_CLIPPER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/prc_pkg.sv */
`default_nettype none

package prc_pkg;

	localparam int ExtentDefault   = 8192;
	localparam int FracBitsDefault = 8;
	localparam int VertW           = 16;
	localparam int PointW          = 22;

endpackage

`default_nettype wire

/* design/prc_if.sv */
`default_nettype none

interface prc_vert_if;
	import prc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VertW-1:0] vert_x;
	logic signed [VertW-1:0] vert_y;
	logic                    line_start;

	modport source (output valid, vert_x, vert_y, line_start, input ready);
	modport sink (input valid, vert_x, vert_y, line_start, output ready);
endinterface

interface prc_point_if;
	import prc_pkg::*;

	logic              valid;
	logic              ready;
	logic [PointW-1:0] point_x;
	logic [PointW-1:0] point_y;
	logic              piece_start;
	logic              last_of_run;

	modport source (output valid, point_x, point_y, piece_start, last_of_run, input ready);
	modport sink (input valid, point_x, point_y, piece_start, last_of_run, output ready);
endinterface

`default_nettype wire

/* design/prc_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits, so the top of the dividend preloads the
// remainder directly.
module prc_div #(
	parameter int DW = 46,
	parameter int VW = 18,
	parameter int QW = 22
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [QW-1:0]      quotient
);
	localparam int CntW = $clog2(QW + 1);

	logic [VW-1:0]   rem_q;
	logic [QW-1:0]   work_q;
	logic [VW-1:0]   dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic        ge;

	assign trial = {rem_q, work_q[QW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			work_q <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= VW'(dividend >> QW);
			work_q <= dividend[QW-1:0];
			dvs_q  <= divisor;
			cnt_q  <= CntW'(QW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[VW-1:0] : trial[VW-1:0];
			work_q <= {work_q[QW-2:0], ge};
			cnt_q  <= cnt_q - CntW'(1);
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = work_q;
endmodule

`default_nettype wire

/* design/polyline_rect_clipper.sv */
// Polyline clipper against the closed square [0, EXTENT] x [0, EXTENT].
// Input channel vert: one vertex per beat, line_start marks the first vertex
// of a polyline. Output channel point: clipped points in fixed point with
// FRAC_BITS fraction bits; piece_start opens a sub-polyline and last_of_run
// flags the final point caused by one vertex. A vertex yields zero to two
// points.
// The block takes one vertex at a time; ready is high only while idle.
// A first vertex or an inside-to-inside step goes straight to its point, if it
// yields one. A crossing step runs Liang-Barsky over the edges x-min, x-max,
// y-min and y-max in turn, stopping at a rejection, on one shared 18x18
// multiplier, then a final order check of entry against exit when both ends
// lie outside; each crossing coordinate then goes through the shared
// restoring divider, QW = clog2(EXTENT * 2^FRAC_BITS + 1), 22 at the defaults.
// Results sit in an output register; a new vertex is accepted while the last
// point of the previous one waits there. A stalled receiver holds the block
// only when it needs the output register for the next point.
// Reset clears the stored previous vertex, so the next vertex starts a line.
`default_nettype none

module polyline_rect_clipper #(
	parameter int EXTENT    = prc_pkg::ExtentDefault,
	parameter int FRAC_BITS = prc_pkg::FracBitsDefault
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	prc_vert_if.sink    vert,
	prc_point_if.source point
);
	import prc_pkg::*;

	localparam int CW   = VertW + 2;
	localparam int PW   = 2 * CW;
	localparam int NumW = PW;
	localparam int DW   = NumW + FRAC_BITS + 2;
	localparam int VW   = CW;
	localparam int QW   = $clog2(EXTENT * (2 ** FRAC_BITS) + 1);

	localparam logic signed [VertW:0] ExtV = (VertW + 1)'(EXTENT);
	localparam logic signed [CW-1:0]  ExtE = CW'(EXTENT);

	typedef struct packed {
		logic signed [CW-1:0] n;
		logic [CW-2:0]        d;
	} frac_t;

	typedef enum logic [1:0] {K_VERT, K_EN, K_EX} kind_t;
	typedef enum logic [1:0] {C_REJ, C_UPD, C_ORD} cstep_t;
	typedef enum logic [1:0] {E_XMIN, E_XMAX, E_YMIN, E_YMAX} edge_t;
	typedef enum logic [3:0] {
		S_IDLE, S_NEXT, S_EDGE, S_CMP_L, S_CMP_R, S_CMP_D, S_PLAN,
		S_LERP_P1, S_LERP_P2, S_LERP_SUM, S_DIV_GO, S_DIV, S_EMIT
	} state_t;

	function automatic logic is_inside(input logic signed [VertW-1:0] x,
			input logic signed [VertW-1:0] y);
		logic signed [VertW:0] xe;
		logic signed [VertW:0] ye;
		xe = {x[VertW-1], x};
		ye = {y[VertW-1], y};
		return !x[VertW-1] && (xe <= ExtV) && !y[VertW-1] && (ye <= ExtV);
	endfunction

	function automatic logic [PointW-1:0] vert_fix(input logic signed [VertW-1:0] v);
		logic [VertW+FRAC_BITS-1:0] w;
		w = (VertW + FRAC_BITS)'($unsigned(v)) << FRAC_BITS;
		if (v[VertW-1])
			w = '0;
		return PointW'(w);
	endfunction

	state_t state_q;
	edge_t  edge_q;
	cstep_t cstep_q;
	kind_t  kind0_q;
	kind_t  kind1_q;

	logic signed [VertW-1:0] prev_x_q;
	logic signed [VertW-1:0] prev_y_q;
	logic                    prev_in_q;
	logic                    have_prev_q;
	logic signed [VertW-1:0] ax_q;
	logic signed [VertW-1:0] ay_q;
	logic signed [VertW-1:0] bx_q;
	logic signed [VertW-1:0] by_q;
	logic signed [VertW:0]   dx_q;
	logic signed [VertW:0]   dy_q;
	logic                    ain_q;
	logic                    bin_q;
	logic                    first_q;
	logic                    ok_q;
	logic                    order_q;
	logic                    pneg_q;
	logic                    coord_q;
	logic [1:0]              slot_q;
	logic [1:0]              nres_q;
	frac_t                   en_q;
	frac_t                   ex_q;
	frac_t                   t_q;
	logic signed [PW-1:0]    prod_a_q;
	logic signed [PW-1:0]    prod_b_q;
	logic [NumW-1:0]         num_q;
	logic [PointW-1:0]       px_q;
	logic [PointW-1:0]       py_q;
	logic                    out_valid_q;
	logic [PointW-1:0]       out_x_q;
	logic [PointW-1:0]       out_y_q;
	logic                    out_ps_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    cur_in;
	logic                    first;
	logic signed [VertW:0]   dx_n;
	logic signed [VertW:0]   dy_n;
	logic signed [CW-1:0]    axe;
	logic signed [CW-1:0]    aye;
	logic signed [CW-1:0]    dxe;
	logic signed [CW-1:0]    dye;
	logic signed [CW-1:0]    p_e;
	logic signed [CW-1:0]    q_e;
	logic                    p_neg;
	frac_t                   t_e;
	frac_t                   cmp_a;
	frac_t                   cmp_b;
	kind_t                   kind_cur;
	frac_t                   t_l;
	logic signed [CW-1:0]    lerp_a;
	logic signed [CW-1:0]    lerp_d;
	logic signed [CW-1:0]    mul_a;
	logic signed [CW-1:0]    mul_b;
	logic signed [PW-1:0]    mul_p;
	logic signed [PW:0]      sum;
	logic [NumW-1:0]         num_n;
	logic                    lt;
	logic                    ps_cur;
	logic                    last_cur;
	logic                    emit_fire;
	logic                    div_start;
	logic                    div_done;
	logic [DW-1:0]           div_dividend;
	logic [VW-1:0]           div_divisor;
	logic [QW-1:0]           div_quot;
	logic [PointW-1:0]       div_pt;

	assign accept = vert.valid && vert.ready;
	assign cur_in = is_inside(vert.vert_x, vert.vert_y);
	assign first  = vert.line_start || !have_prev_q;
	assign dx_n   = {vert.vert_x[VertW-1], vert.vert_x} - {prev_x_q[VertW-1], prev_x_q};
	assign dy_n   = {vert.vert_y[VertW-1], vert.vert_y} - {prev_y_q[VertW-1], prev_y_q};

	assign axe = {{2{ax_q[VertW-1]}}, ax_q};
	assign aye = {{2{ay_q[VertW-1]}}, ay_q};
	assign dxe = {dx_q[VertW], dx_q};
	assign dye = {dy_q[VertW], dy_q};

	// p and q of the current edge, folded into a positive-denominator t
	always_comb begin
		case (edge_q)
			E_XMIN: begin
				p_e = -dxe;
				q_e = axe;
			end
			E_XMAX: begin
				p_e = dxe;
				q_e = ExtE - axe;
			end
			E_YMIN: begin
				p_e = -dye;
				q_e = aye;
			end
			default: begin
				p_e = dye;
				q_e = ExtE - aye;
			end
		endcase
		p_neg = p_e[CW-1];
		t_e.d = p_neg ? (CW - 1)'(-p_e) : (CW - 1)'(p_e);
		t_e.n = p_neg ? -q_e : q_e;
	end

	// operands of the fraction compare cmp_a < cmp_b
	always_comb begin
		case (cstep_q)
			C_REJ: begin
				cmp_a = pneg_q ? ex_q : t_q;
				cmp_b = pneg_q ? t_q : en_q;
			end
			C_UPD: begin
				cmp_a = pneg_q ? en_q : t_q;
				cmp_b = pneg_q ? t_q : ex_q;
			end
			default: begin
				cmp_a = en_q;
				cmp_b = ex_q;
			end
		endcase
	end

	assign kind_cur = slot_q[0] ? kind1_q : kind0_q;
	assign t_l      = (kind_cur == K_EN) ? en_q : ex_q;
	assign lerp_a   = coord_q ? aye : axe;
	assign lerp_d   = coord_q ? dye : dxe;

	// the shared multiplier
	always_comb begin
		case (state_q)
			S_CMP_L: begin
				mul_a = cmp_a.n;
				mul_b = {1'b0, cmp_b.d};
			end
			S_CMP_R: begin
				mul_a = cmp_b.n;
				mul_b = {1'b0, cmp_a.d};
			end
			S_LERP_P1: begin
				mul_a = lerp_a;
				mul_b = {1'b0, t_l.d};
			end
			S_LERP_P2: begin
				mul_a = t_l.n;
				mul_b = lerp_d;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign lt    = prod_a_q < prod_b_q;
	assign sum   = {prod_a_q[PW-1], prod_a_q} + {prod_b_q[PW-1], prod_b_q};
	assign num_n = sum[PW] ? '0 : sum[NumW-1:0];

	// (2 * num * 2^F + d) / (2 * d) rounds num * 2^F / d to nearest, ties up
	assign div_start    = (state_q == S_DIV_GO);
	assign div_dividend = (DW'(num_q) << (FRAC_BITS + 1)) + DW'(t_l.d);
	assign div_divisor  = {t_l.d, 1'b0};
	assign div_pt       = PointW'(div_quot);

	assign ps_cur    = (kind_cur == K_EN) || ((kind_cur == K_VERT) && first_q);
	assign last_cur  = (slot_q + 2'd1) == nres_q;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || point.ready);

	prc_div #(
		.DW(DW),
		.VW(VW),
		.QW(QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			edge_q      <= E_XMIN;
			cstep_q     <= C_REJ;
			kind0_q     <= K_VERT;
			kind1_q     <= K_VERT;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_in_q   <= 1'b0;
			have_prev_q <= 1'b0;
			ax_q        <= '0;
			ay_q        <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			ain_q       <= 1'b0;
			bin_q       <= 1'b0;
			first_q     <= 1'b0;
			ok_q        <= 1'b0;
			order_q     <= 1'b0;
			pneg_q      <= 1'b0;
			coord_q     <= 1'b0;
			slot_q      <= '0;
			nres_q      <= '0;
			en_q        <= '0;
			ex_q        <= '0;
			t_q         <= '0;
			prod_a_q    <= '0;
			prod_b_q    <= '0;
			num_q       <= '0;
			px_q        <= '0;
			py_q        <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_ps_q    <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && point.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ax_q        <= prev_x_q;
						ay_q        <= prev_y_q;
						bx_q        <= vert.vert_x;
						by_q        <= vert.vert_y;
						dx_q        <= dx_n;
						dy_q        <= dy_n;
						ain_q       <= prev_in_q;
						bin_q       <= cur_in;
						first_q     <= first;
						prev_x_q    <= vert.vert_x;
						prev_y_q    <= vert.vert_y;
						prev_in_q   <= cur_in;
						have_prev_q <= 1'b1;
						slot_q      <= '0;
						en_q        <= '{n: '0, d: (CW - 1)'(1)};
						ex_q        <= '{n: CW'(1), d: (CW - 1)'(1)};
						edge_q      <= E_XMIN;
						ok_q        <= 1'b1;
						order_q     <= 1'b0;
						if (first || (prev_in_q && cur_in)) begin
							kind0_q <= K_VERT;
							nres_q  <= (first && !cur_in) ? 2'd0 : 2'd1;
							state_q <= S_NEXT;
						end else begin
							state_q <= S_EDGE;
						end
					end
				end

				S_NEXT: begin
					if (slot_q == nres_q) begin
						state_q <= S_IDLE;
					end else if (kind_cur == K_VERT) begin
						px_q    <= vert_fix(bx_q);
						py_q    <= vert_fix(by_q);
						state_q <= S_EMIT;
					end else begin
						coord_q <= 1'b0;
						state_q <= S_LERP_P1;
					end
				end

				S_EDGE: begin
					if (p_e == '0) begin
						// parallel to this edge: outside it means a miss
						if (q_e < 0) begin
							ok_q    <= 1'b0;
							state_q <= S_PLAN;
						end else if (edge_q == E_YMAX) begin
							cstep_q <= C_ORD;
							state_q <= (!ain_q && !bin_q) ? S_CMP_L : S_PLAN;
						end else begin
							edge_q <= edge_t'(edge_q + 2'd1);
						end
					end else begin
						t_q     <= t_e;
						pneg_q  <= p_neg;
						cstep_q <= C_REJ;
						state_q <= S_CMP_L;
					end
				end

				S_CMP_L: begin
					prod_a_q <= mul_p;
					state_q  <= S_CMP_R;
				end

				S_CMP_R: begin
					prod_b_q <= mul_p;
					state_q  <= S_CMP_D;
				end

				S_CMP_D: begin
					case (cstep_q)
						C_REJ: begin
							if (lt) begin
								ok_q    <= 1'b0;
								state_q <= S_PLAN;
							end else begin
								cstep_q <= C_UPD;
								state_q <= S_CMP_L;
							end
						end
						C_UPD: begin
							if (lt) begin
								if (pneg_q)
									en_q <= t_q;
								else
									ex_q <= t_q;
							end
							if (edge_q == E_YMAX) begin
								cstep_q <= C_ORD;
								state_q <= (!ain_q && !bin_q) ? S_CMP_L : S_PLAN;
							end else begin
								edge_q  <= edge_t'(edge_q + 2'd1);
								state_q <= S_EDGE;
							end
						end
						default: begin
							order_q <= lt;
							state_q <= S_PLAN;
						end
					endcase
				end

				S_PLAN: begin
					slot_q  <= '0;
					state_q <= S_NEXT;
					if (ain_q) begin
						kind0_q <= K_EX;
						nres_q  <= ok_q ? 2'd1 : 2'd0;
					end else if (bin_q) begin
						if (ok_q) begin
							kind0_q <= K_EN;
							kind1_q <= K_VERT;
							nres_q  <= 2'd2;
						end else begin
							kind0_q <= K_VERT;
							nres_q  <= 2'd1;
						end
					end else begin
						kind0_q <= K_EN;
						kind1_q <= K_EX;
						nres_q  <= (ok_q && order_q) ? 2'd2 : 2'd0;
					end
				end

				S_LERP_P1: begin
					prod_a_q <= mul_p;
					state_q  <= S_LERP_P2;
				end

				S_LERP_P2: begin
					prod_b_q <= mul_p;
					state_q  <= S_LERP_SUM;
				end

				S_LERP_SUM: begin
					num_q   <= num_n;
					state_q <= S_DIV_GO;
				end

				S_DIV_GO: begin
					state_q <= S_DIV;
				end

				S_DIV: begin
					if (div_done) begin
						if (coord_q) begin
							py_q    <= div_pt;
							state_q <= S_EMIT;
						end else begin
							px_q    <= div_pt;
							coord_q <= 1'b1;
							state_q <= S_LERP_P1;
						end
					end
				end

				S_EMIT: begin
					if (emit_fire) begin
						out_x_q    <= px_q;
						out_y_q    <= py_q;
						out_ps_q   <= ps_cur;
						out_last_q <= last_cur;
						slot_q     <= slot_q + 2'd1;
						state_q    <= S_NEXT;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign vert.ready        = (state_q == S_IDLE);
	assign point.valid       = out_valid_q;
	assign point.point_x     = out_x_q;
	assign point.point_y     = out_y_q;
	assign point.piece_start = out_ps_q;
	assign point.last_of_run = out_last_q;
endmodule

`default_nettype wire

/* design/prc_checker.sv */
`default_nettype none
`include "polyline_rect_clipper_defines.svh"

module prc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_piece_start,
	input wire logic out_last
);
	// set after a beat that leaves its run open
	logic second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			second_q <= !out_last;
		end
	end

	`PRC_ASSERT_NEXT(a_one_vertex_at_a_time, in_valid && in_ready, !in_ready, "vertex accepted while busy")
	`PRC_ASSERT_SAME(a_open_run_holds_input, out_valid && !out_last, !in_ready, "vertex taken during open run")
	`PRC_ASSERT_SAME(a_second_beat_closes, out_valid && out_ready && second_q, out_last && !out_piece_start, "bad second point of run")
	`PRC_ASSERT_NEXT(a_point_held, out_valid && !out_ready, out_valid, "point dropped while stalled")
endmodule

bind polyline_rect_clipper prc_checker u_prc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (vert.valid),
	.in_ready       (vert.ready),
	.out_valid      (point.valid),
	.out_ready      (point.ready),
	.out_piece_start(point.piece_start),
	.out_last       (point.last_of_run)
);

`default_nettype wire
